[rtl/mfmsfd_pkg.sv]
`default_nettype none
package mfmsfd_pkg;

  localparam logic [15:0] SYNC_WORD       = 16'h4489;
  localparam logic [31:0] MFM_MASK        = 32'h5555_5555;
  localparam int unsigned DATA_SKIP_WORDS = 28;
  localparam logic [7:0]  DATA_LONGS_RST  = 8'd80;

  localparam logic CFG_WANTED_SECTOR = 1'b0;
  localparam logic CFG_DATA_LONGS    = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic STATUS_FOUND    = 1'b0;
  localparam logic STATUS_NOTFOUND = 1'b1;

  typedef enum logic [1:0] {
    PH_SEARCHING,
    PH_SECTOR,
    PH_COMPLETE
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] data_long;
    logic [6:0]  long_index;
    logic        status;
    logic [7:0]  sector_found;
    logic        last;
  } result_t;

  function automatic logic [31:0] mfm_decode(input logic [31:0] odd, input logic [31:0] even);
    return ((odd & MFM_MASK) << 1) | (even & MFM_MASK);
  endfunction

endpackage
`default_nettype wire

[rtl/mfmsfd_ram.sv]
`default_nettype none
module mfmsfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/mfm_sector_find_decode.sv]
// mfm sector finder and decoder
// input channel (in_valid_i / in_ready_o): one raw mfm track word per request,
// with track_end_i set on the final word of a track. after each 0x4489 sync
// the next four words are decoded as the sector info; the first match against
// wanted_sector starts the data area 28 words after the word that follows
// the sync. odd-half longs go to an internal ram, and decoded longs come out
// during the even half, up to data_longs of them.
// output channel (out_valid_o / out_ready_i): data results (kind 0) and one
// status result (kind 1) per track; last_o marks the final result of a word.
// results of a word are written into the result queue as the word is taken, and leave it in order.
// throughput: one word per cycle; a word is taken whenever the 4-entry result
// queue has room for two results, so a receiver that takes a result every
// cycle never slows the input side. a stalled receiver fills the queue and
// then in_ready_o drops until entries drain.
// reset clears the scan state, the queue and the registers (wanted_sector 0,
// data_longs 80); the odd-half ram needs no clearing pass.
// configuration writes take effect on the edge where cfg_we_i is high.
`default_nettype none
module mfm_sector_find_decode
  import mfmsfd_pkg::*;
#(
  parameter int HALF_LONGS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] mfm_word_i,
  input  wire logic        track_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [31:0]      data_long_o,
  output logic [6:0]       long_index_o,
  output logic             status_o,
  output logic [7:0]       sector_found_o,
  output logic             last_o
);

  localparam int KW   = (HALF_LONGS > 1) ? $clog2(HALF_LONGS) : 1;
  localparam int WCW  = $clog2(DATA_SKIP_WORDS + 4 * HALF_LONGS + 2);
  localparam int CMPW = (KW > 8) ? KW : 8;
  localparam logic [WCW-1:0] WC_START  = WCW'(4);
  localparam logic [WCW-1:0] WC_SKIP   = WCW'(DATA_SKIP_WORDS);
  localparam logic [WCW-1:0] WC_DATA0  = WCW'(DATA_SKIP_WORDS + 1);
  localparam logic [WCW-1:0] HALF_WDS  = WCW'(2 * HALF_LONGS);
  localparam logic [WCW-1:0] HALF_LAST = WCW'(2 * HALF_LONGS - 1);

  // configuration
  logic [7:0] wanted_sector_q, data_longs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_sector_q <= 8'd0;
      data_longs_q    <= DATA_LONGS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WANTED_SECTOR: wanted_sector_q <= cfg_wdata_i;
        CFG_DATA_LONGS:    data_longs_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // scan state
  logic [15:0]    win0_q, win1_q, win2_q, win0_d, win1_d, win2_d;
  logic [3:0]     sync_q, sync_d;
  phase_e         phase_q, phase_d;
  logic [WCW-1:0] wc_q, wc_d;
  logic [7:0]     msec_q, msec_d;

  logic        in_fire;
  logic [31:0] info_long, cur_long, odd_rd;
  logic [WCW-1:0] wc_inc, r_off, e_off;
  logic        in_data, in_odd_half, sec_done;
  logic [KW-1:0] k_idx;
  logic        ram_we, ram_re, emit_data;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cur_long = {win0_q, mfm_word_i};
  assign info_long = mfm_decode({win2_q, win1_q}, cur_long);
  assign wc_inc   = wc_q + WCW'(1);
  assign r_off    = wc_inc - WC_DATA0;
  assign e_off    = r_off - HALF_WDS;
  assign in_data  = (phase_q == PH_SECTOR) && (wc_inc > WC_SKIP);
  assign in_odd_half = r_off < HALF_WDS;
  assign k_idx    = e_off[KW:1];
  // last word of the even half
  assign sec_done = in_data && !in_odd_half && (e_off == HALF_LAST);

  // next state
  always_comb begin
    phase_d = phase_q;
    wc_d    = wc_q;
    msec_d  = msec_q;
    win0_d  = mfm_word_i;
    win1_d  = win0_q;
    win2_d  = win1_q;
    sync_d  = {sync_q[2:0], mfm_word_i == SYNC_WORD};
    case (phase_q)
      PH_SEARCHING: begin
        if (sync_q[3] && (info_long[15:8] == wanted_sector_q)) begin
          phase_d = PH_SECTOR;
          wc_d    = WC_START;
          msec_d  = info_long[15:8];
        end
      end
      PH_SECTOR: begin
        wc_d = wc_inc;
        if (sec_done) begin
          phase_d = PH_COMPLETE;
        end
      end
      default: ;
    endcase
    if (track_end_i) begin
      phase_d = PH_SEARCHING;
      wc_d    = '0;
      msec_d  = 8'd0;
      win0_d  = 16'd0;
      win1_d  = 16'd0;
      win2_d  = 16'd0;
      sync_d  = 4'd0;
    end
  end

  // memory control and results
  result_t res0, res1;
  logic [1:0] push_n;

  always_comb begin
    ram_we    = in_fire && in_data && in_odd_half && r_off[0];
    ram_re    = in_fire && in_data && !in_odd_half && !e_off[0];
    emit_data = in_data && !in_odd_half && e_off[0]
                && (CMPW'(k_idx) < CMPW'(data_longs_q));
    res0 = '0;
    res1 = '0;
    push_n = 2'd0;
    if (emit_data) begin
      res0.kind         = KIND_DATA;
      res0.data_long    = mfm_decode(odd_rd, cur_long);
      res0.long_index   = 7'(k_idx);
      res0.status       = STATUS_FOUND;
      res0.sector_found = msec_q;
      res0.last         = !track_end_i;
    end
    if (track_end_i) begin
      res1.kind = KIND_STATUS;
      res1.last = 1'b1;
      // phase after this word's scan step, before the end-of-track clear
      if ((phase_q == PH_COMPLETE) || sec_done) begin
        res1.status       = STATUS_FOUND;
        res1.sector_found = msec_q;
      end else begin
        res1.status       = STATUS_NOTFOUND;
        res1.sector_found = 8'd0;
      end
    end
    if (emit_data && track_end_i) begin
      push_n = 2'd2;
    end else if (emit_data) begin
      push_n = 2'd1;
    end else if (track_end_i) begin
      push_n = 2'd1;
      res0   = res1;
    end
  end

  mfmsfd_ram #(
    .WIDTH(32),
    .DEPTH(HALF_LONGS)
  ) u_odd_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(r_off[KW:1]),
    .wdata_i(cur_long),
    .re_i   (ram_re),
    .raddr_i(k_idx),
    .rdata_o(odd_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q  <= 16'd0;
      win1_q  <= 16'd0;
      win2_q  <= 16'd0;
      sync_q  <= 4'd0;
      phase_q <= PH_SEARCHING;
      wc_q    <= '0;
      msec_q  <= 8'd0;
    end else if (in_fire) begin
      win0_q  <= win0_d;
      win1_q  <= win1_d;
      win2_q  <= win2_d;
      sync_q  <= sync_d;
      phase_q <= phase_d;
      wc_q    <= wc_d;
      msec_q  <= msec_d;
    end
  end

  // result queue, four entries, up to two pushed per request
  result_t    q_mem [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] push_eff;
  result_t    head;

  assign in_ready_o  = cnt_q <= 3'd2;
  assign out_valid_o = cnt_q != 3'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign push_eff    = in_fire ? push_n : 2'd0;
  assign head        = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_eff != 2'd0) begin
      q_mem[wr_ptr_q] <= res0;
    end
    if (push_eff == 2'd2) begin
      q_mem[wr_ptr_q + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_eff;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, push_eff} - {2'b00, pop};
    end
  end

  assign kind_o         = head.kind;
  assign data_long_o    = head.data_long;
  assign long_index_o   = head.long_index;
  assign status_o       = head.status;
  assign sector_found_o = head.sector_found;
  assign last_o         = head.last;

endmodule
`default_nettype wire
